// File: rtl/rles_pkg.sv
package rles_pkg;

	localparam int NUM_LEDS = 16;
	localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

	typedef enum logic [2:0] {
		EFF_SLOW_FLASH = 3'd0,
		EFF_FAST_FLASH = 3'd1,
		EFF_BREATH     = 3'd2,
		EFF_SLOW_RAIN  = 3'd3,
		EFF_FAST_RAIN  = 3'd4,
		EFF_POLICE     = 3'd5,
		EFF_RUNNER     = 3'd6,
		EFF_NONE       = 3'd7
	} effect_t;

	typedef enum logic [1:0] {
		FILL_FLAT,
		FILL_RUNNER_ONE,
		FILL_RUNNER_ALL,
		FILL_RUNNER_CLEAR
	} fill_kind_t;

	// One redraw command from the front part to the drawing part.
	typedef struct packed {
		fill_kind_t  kind;
		logic [23:0] rgb;
		logic [6:0]  pos;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DRAW,
		BK_EMIT
	} back_state_t;

	function automatic logic [23:0] tone(input logic [3:0] idx);
		logic [23:0] c;
		case (idx)
			4'd0: c = 24'hFF0000;
			4'd1: c = 24'h00FF00;
			4'd2: c = 24'h0000FF;
			4'd3: c = 24'hFFFF00;
			4'd4: c = 24'hFFFFFF;
			4'd5: c = 24'h00FFFF;
			4'd6: c = 24'hFF8000;
			4'd7: c = 24'hFFFF80;
			4'd8: c = 24'h80FF00;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

	function automatic logic [5:0] period_of(input effect_t e);
		logic [5:0] p;
		case (e)
			EFF_SLOW_FLASH, EFF_SLOW_RAIN: p = 6'd50;
			EFF_FAST_FLASH, EFF_FAST_RAIN: p = 6'd10;
			EFF_BREATH:  p = 6'd2;
			EFF_POLICE:  p = 6'd5;
			EFF_RUNNER:  p = 6'd3;
			default:     p = 6'd63;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/rles_req_if.sv
interface rles_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [2:0] effect;
	modport source (output valid, req_type, effect, input ready);
	modport sink (input valid, req_type, effect, output ready);
endinterface

// File: rtl/rles_pix_if.sv
interface rles_pix_if;
	logic       valid;
	logic       ready;
	logic [5:0] led_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       frame_last;
	modport source (output valid, led_index, red, green, blue, frame_last, input ready);
	modport sink (input valid, led_index, red, green, blue, frame_last, output ready);
endinterface

// File: rtl/rles_front.sv
module rles_front
	import rles_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rles_req_if.sink   req,
	input  logic [3:0] color_index,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_ready
);

	effect_t     mode_q;
	logic [5:0]  presc_q;
	logic        blink_q;
	logic [3:0]  step_q;
	logic [7:0]  level_q;
	logic        rising_q;
	logic [6:0]  rpos_q;
	logic [1:0]  rphase_q;
	logic [1:0]  rloops_q;

	// Stage 1 holds a pending multiply for breathing.
	logic        mul_pend_s1;
	logic [7:0]  mul_lvl_s1;
	logic [23:0] mul_col_s1;

	logic        take;
	logic        sel;
	logic [5:0]  presc_inc;
	logic        fire;

	assign req.ready = cmd_ready && !mul_pend_s1;
	assign take      = req.valid && req.ready;
	assign sel       = req.req_type;
	assign presc_inc = presc_q + 6'd1;
	assign fire      = !sel && (presc_inc >= period_of(mode_q));

	logic [15:0] pr, pg, pb;
	assign pr = mul_lvl_s1 * mul_col_s1[23:16];
	assign pg = mul_lvl_s1 * mul_col_s1[15:8];
	assign pb = mul_lvl_s1 * mul_col_s1[7:0];

	// Next state and command for the accepted beat.
	effect_t     n_mode;
	logic [5:0]  n_presc;
	logic        n_blink;
	logic [3:0]  n_step;
	logic [7:0]  n_level;
	logic        n_rising;
	logic [6:0]  n_rpos;
	logic [1:0]  n_rphase;
	logic [1:0]  n_rloops;
	logic        n_cmd;
	logic        n_mul;
	cmd_t        c;
	logic [8:0]  lvl_w;
	logic [6:0]  rp1;
	logic [1:0]  rl1;
	effect_t     new_mode;

	always_comb begin
		n_mode = mode_q; n_presc = presc_q; n_blink = blink_q; n_step = step_q;
		n_level = level_q; n_rising = rising_q; n_rpos = rpos_q; n_rphase = rphase_q;
		n_rloops = rloops_q; n_cmd = 1'b0; n_mul = 1'b0;
		c = '{kind: FILL_FLAT, rgb: 24'h0, pos: 7'd0};
		lvl_w = '0;
		rp1 = rpos_q + 7'd1;
		rl1 = rloops_q + 2'd1;
		new_mode = effect_t'(req.effect);
		if (sel) begin
			if (new_mode != EFF_NONE) begin
				n_mode = new_mode; n_presc = 6'd0; n_cmd = 1'b1;
				case (new_mode)
					EFF_SLOW_FLASH, EFF_FAST_FLASH: begin
						n_blink = 1'b0; c.rgb = tone(color_index);
					end
					EFF_BREATH: begin
						n_level = 8'd0; n_rising = 1'b1; n_step = 4'd0;
						c.kind = FILL_RUNNER_CLEAR; c.pos = 7'h7F;
					end
					EFF_SLOW_RAIN, EFF_FAST_RAIN: begin
						n_blink = 1'b0; n_step = 4'd0;
						c.kind = FILL_RUNNER_CLEAR; c.pos = 7'h7F;
					end
					EFF_POLICE: begin
						n_blink = 1'b0; c.rgb = 24'hFF0000;
					end
					default: begin
						n_rpos = 7'd0; n_rphase = 2'd0; n_rloops = 2'd0;
					end
				endcase
			end
		end else if (mode_q != EFF_NONE) begin
			n_presc = presc_inc;
			if (fire) begin
				n_presc = 6'd0; n_cmd = 1'b1;
				case (mode_q)
					EFF_SLOW_FLASH, EFF_FAST_FLASH: begin
						n_blink = !blink_q;
						c.rgb = n_blink ? tone(color_index) : 24'h0;
					end
					EFF_BREATH: begin
						lvl_w = rising_q ? {1'b0, level_q} + 9'd8 : {1'b0, level_q} - 9'd8;
						if (rising_q && lvl_w >= 9'd250) begin
							n_level = 8'd250; n_rising = 1'b0;
						end else if (!rising_q && (level_q <= 8'd8)) begin
							n_level = 8'd0; n_rising = 1'b1;
							n_step = (step_q == 4'd9) ? 4'd0 : step_q + 4'd1;
						end else begin
							n_level = lvl_w[7:0];
						end
						n_cmd = 1'b0; n_mul = 1'b1;
					end
					EFF_SLOW_RAIN, EFF_FAST_RAIN: begin
						n_blink = !blink_q;
						if (blink_q) n_step = (step_q == 4'd9) ? 4'd0 : step_q + 4'd1;
						c.rgb = n_blink ? tone(n_step) : 24'h0;
					end
					EFF_POLICE: begin
						n_blink = !blink_q;
						c.rgb = n_blink ? 24'hFF0000 : 24'h0000FF;
					end
					default: begin
						c.pos = rpos_q;
						case (rphase_q)
							2'd0: begin
								c.kind = FILL_RUNNER_ONE; n_rpos = rp1;
								if (rp1 >= 7'(NUM_LEDS)) begin
									n_rpos = 7'd0; n_rphase = 2'd1; n_rloops = 2'd0;
								end
							end
							2'd1: begin
								c.kind = FILL_RUNNER_ALL; n_rpos = rp1;
								if (rp1 >= 7'(NUM_LEDS)) begin
									n_rpos = 7'd0; n_rloops = rl1;
									if (rl1 >= 2'd2) n_rphase = 2'd2;
								end
							end
							default: begin
								c.kind = FILL_RUNNER_CLEAR;
								if (rpos_q < 7'(NUM_LEDS)) begin
									n_rpos = rp1;
								end else begin
									n_rpos = 7'd0; n_rphase = 2'd0; n_rloops = 2'd0;
								end
							end
						endcase
					end
				endcase
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= EFF_SLOW_FLASH; presc_q <= '0; blink_q <= 1'b0; step_q <= '0;
			level_q <= '0; rising_q <= 1'b1; rpos_q <= '0; rphase_q <= '0;
			rloops_q <= '0; mul_pend_s1 <= 1'b0;
		end else begin
			if (take) begin
				mode_q <= n_mode; presc_q <= n_presc; blink_q <= n_blink; step_q <= n_step;
				level_q <= n_level; rising_q <= n_rising; rpos_q <= n_rpos;
				rphase_q <= n_rphase; rloops_q <= n_rloops;
			end
			if (take && n_mul) mul_pend_s1 <= 1'b1;
			else if (cmd_ready) mul_pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && n_mul) begin
			mul_lvl_s1 <= n_level;
			mul_col_s1 <= tone(n_step);
		end
	end

	// Breathing commands come from the multiply stage, the rest directly.
	always_comb begin
		if (mul_pend_s1) begin
			cmd_valid = 1'b1;
			cmd = '{kind: FILL_FLAT, rgb: {pr[15:8], pg[15:8], pb[15:8]}, pos: 7'd0};
		end else begin
			cmd_valid = take && n_cmd;
			cmd = c;
		end
	end

endmodule

// File: rtl/rles_fifo.sv
module rles_fifo
	import rles_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_cmd   = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Two-entry command queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end

endmodule

// File: rtl/rles_back.sv
module rles_back
	import rles_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  cmd_t     cmd,
	rles_pix_if.source pix
);

	back_state_t      st_q, st_n;
	cmd_t             cmd_q;
	logic [23:0]      frame_q [NUM_LEDS];
	logic [LED_W-1:0] idx_q;
	logic             out_v_q;
	logic [5:0]       out_idx_q;
	logic [23:0]      out_rgb_q;
	logic             out_last_q;
	logic             last_led;
	logic             slot_free;

	assign last_led  = idx_q == LED_W'(NUM_LEDS - 1);
	assign slot_free = !out_v_q || pix.ready;

	// Next state.
	always_comb begin
		st_n = st_q;
		case (st_q)
			BK_IDLE: if (cmd_valid) st_n = BK_DRAW;
			BK_DRAW: st_n = BK_EMIT;
			BK_EMIT: if (slot_free && last_led) st_n = BK_IDLE;
			default: st_n = BK_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd_ready = st_q == BK_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE; idx_q <= '0; out_v_q <= 1'b0;
			for (int i = 0; i < NUM_LEDS; i++) frame_q[i] <= '0;
		end else begin
			st_q <= st_n;
			if (st_q == BK_DRAW) begin
				for (int i = 0; i < NUM_LEDS; i++) begin
					case (cmd_q.kind)
						FILL_FLAT: frame_q[i] <= cmd_q.rgb;
						FILL_RUNNER_ONE: frame_q[i] <= (7'(i) == cmd_q.pos) ?
							tone(4'(i > 9 ? 9 : i)) : 24'h0;
						FILL_RUNNER_ALL: frame_q[i] <= tone(4'(i > 9 ? 9 : i));
						default: if (7'(i) == cmd_q.pos) frame_q[i] <= 24'h0;
					endcase
				end
				idx_q <= '0;
			end
			if (st_q == BK_EMIT && slot_free) begin
				out_v_q <= 1'b1;
				idx_q <= last_led ? '0 : idx_q + LED_W'(1);
			end else if (pix.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && cmd_valid) cmd_q <= cmd;
		if (st_q == BK_EMIT && slot_free) begin
			out_idx_q  <= 6'(idx_q);
			out_rgb_q  <= frame_q[idx_q];
			out_last_q <= last_led;
		end
	end

	assign pix.valid      = out_v_q;
	assign pix.led_index  = out_idx_q;
	assign pix.red        = out_rgb_q[23:16];
	assign pix.green      = out_rgb_q[15:8];
	assign pix.blue       = out_rgb_q[7:0];
	assign pix.frame_last = out_last_q;

endmodule

// File: rtl/rgb_led_effect_sequencer.sv
// Effect engine for a NUM_LEDS strip. A select beat (not EFF_NONE) sets the
// effect and emits a frame; a tick beat emits a frame when the period elapses.
// Each frame is NUM_LEDS pixel beats, one per cycle while the sink is ready,
// the last flagged; the drawing unit takes no new command until it is out.
// Redraw-free ticks are taken while the queue has room and no multiply pends.
module rgb_led_effect_sequencer
	import rles_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	rles_req_if.sink   req,
	rles_pix_if.source pix
);

	logic [3:0] color_index_q;
	logic       f_valid, f_ready, q_valid, q_ready;
	cmd_t       f_cmd, q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) color_index_q <= '0;
		else if (cfg_we) color_index_q <= cfg_wdata;
	end

	rles_front u_front (.clk, .arst_n, .req, .color_index(color_index_q),
		.cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready));
	rles_fifo u_fifo (.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
		.out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd));
	rles_back u_back (.clk, .arst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.pix);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.frame_last |-> pix.led_index == 6'(NUM_LEDS - 1))
		else $error("last flag off the final LED");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> pix.led_index < 6'(NUM_LEDS))
		else $error("LED index out of range");

endmodule
